// ----- rtl/point_to_depth_pixel_projector_macros.svh -----
`ifndef POINT_TO_DEPTH_PIXEL_PROJECTOR_MACROS_SVH
`define POINT_TO_DEPTH_PIXEL_PROJECTOR_MACROS_SVH
// Implication in the same cycle, disabled in reset
`define PTD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication in the next cycle, disabled in reset
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/ptd_pkg.sv -----
package ptd_pkg;
  localparam int FOCAL_W = 20;
  localparam int SIZE_W  = 13;
  localparam int DEPTH_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_WIDTH    = 3'd4,
    CFG_HEIGHT   = 3'd5
  } ptd_cfg_e;

  localparam logic [FOCAL_W-1:0] FOCAL_X_RST  = 20'd149152;
  localparam logic [FOCAL_W-1:0] FOCAL_Y_RST  = 20'd149169;
  localparam logic [FOCAL_W-1:0] CENTER_X_RST = 20'd80140;
  localparam logic [FOCAL_W-1:0] CENTER_Y_RST = 20'd61042;
  localparam logic [SIZE_W-1:0]  WIDTH_RST    = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST   = 13'd480;

  // sideband that rides with each item down the pipe
  typedef struct packed {
    logic               keep;
    logic [DEPTH_W-1:0] depth;
  } ptd_side_t;
endpackage

// ----- rtl/point_to_depth_pixel_projector.sv -----
// Channel   Dir  Handshake           Payload
// s_axis    in   tvalid/tready       tdata: x_pos, y_pos, z_pos; tuser: point_bad
// m_axis    out  tvalid/tready       tdata: column, row, depth_mm; tuser: write_pixel
// cfg       in   cfg_we_i            cfg_index_i, cfg_data_i
//
// One item per cycle sustained while m_axis is not stalled; the registers are
// two product/sum stages, one divider stage per quotient bit, output register.
// The pipeline moves as a whole: it holds when the output register is full
// and not taken, and s_axis_tready_o follows that enable.
// Reset clears the valid bits and loads the register defaults.
`include "point_to_depth_pixel_projector_macros.svh"
module point_to_depth_pixel_projector import ptd_pkg::*; #(
  parameter int COORD_BITS       = 24,
  parameter int PIXEL_INDEX_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // x_pos, y_pos, z_pos from bit 0 up, zero padded
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // point_bad
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // column, row, depth_mm from bit 0 up, zero padded
  output logic [((2*PIXEL_INDEX_BITS+16+7)/8)*8-1:0] m_axis_tdata_o,
  // write_pixel
  output logic                 m_axis_tuser_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FOCAL_W-1:0]   cfg_data_i
);
  localparam int CB   = COORD_BITS;
  localparam int P    = PIXEL_INDEX_BITS;
  localparam int W    = CB + P + 22;
  localparam int DW   = CB + 8;
  localparam int LAST = P + 2;
  localparam int OW   = ((2*PIXEL_INDEX_BITS+16+7)/8)*8;

  logic [FOCAL_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [SIZE_W-1:0]  width_q, height_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        CFG_CENTER_X: center_x_q <= cfg_data_i;
        CFG_CENTER_Y: center_y_q <= cfg_data_i;
        CFG_WIDTH:    width_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic              en;
  logic [LAST:0]     valid_q;
  logic signed [CB-1:0] x_in, y_in, z_in;

  assign en              = !valid_q[LAST] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = valid_q[LAST];
  assign x_in = $signed(s_axis_tdata_i[CB-1:0]);
  assign y_in = $signed(s_axis_tdata_i[2*CB-1:CB]);
  assign z_in = $signed(s_axis_tdata_i[3*CB-1:2*CB]);

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAST-1:0], s_axis_tvalid_i};
    end
  end

  // reject test and depth at entry
  ptd_side_t          side_d;
  ptd_side_t          side_q [LAST];
  logic [CB+16:0]     z_ext;
  logic [CB+16:0]     z_mm;

  always_comb begin
    z_ext       = (CB+17)'($unsigned(z_in));
    z_mm        = z_ext >> 4;
    side_d.keep = !s_axis_tuser_i &&
                  ($signed({{18{z_in[CB-1]}}, z_in, 4'd0}) >
                   $signed({(CB+2)'(0), focal_y_q}));
    side_d.depth = (z_mm > (CB+17)'(65535)) ? 16'hFFFF : z_mm[DEPTH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < LAST; k++) side_q[k] <= side_q[k-1];
    end
  end

  // per-axis front and divider chain
  logic [W-1:0]  rem_x [P+1];
  logic [W-1:0]  rem_y [P+1];
  logic [DW-1:0] den_x [P+1];
  logic [DW-1:0] den_y [P+1];
  logic [P-1:0]  q_x   [P+1];
  logic [P-1:0]  q_y   [P+1];
  logic          ovf_x [P+1];
  logic          ovf_y [P+1];

  assign q_x[0] = '0;
  assign q_y[0] = '0;

  ptd_axis_front #(.CB(CB), .P(P), .W(W), .DW(DW)) u_front_x (
    .clk_i, .en_i(en), .p_i(x_in), .z_i(z_in), .focal_i(focal_x_q),
    .center_i(center_x_q), .rem_o(rem_x[0]), .den_o(den_x[0]), .ovf_o(ovf_x[0])
  );

  ptd_axis_front #(.CB(CB), .P(P), .W(W), .DW(DW)) u_front_y (
    .clk_i, .en_i(en), .p_i(y_in), .z_i(z_in), .focal_i(focal_y_q),
    .center_i(center_y_q), .rem_o(rem_y[0]), .den_o(den_y[0]), .ovf_o(ovf_y[0])
  );

  for (genvar k = 0; k < P; k++) begin : g_div
    ptd_div_step #(.W(W), .DW(DW), .P(P), .SHIFT(P-1-k)) u_step_x (
      .clk_i, .en_i(en), .rem_i(rem_x[k]), .den_i(den_x[k]), .q_i(q_x[k]),
      .ovf_i(ovf_x[k]), .rem_o(rem_x[k+1]), .den_o(den_x[k+1]), .q_o(q_x[k+1]),
      .ovf_o(ovf_x[k+1])
    );
    ptd_div_step #(.W(W), .DW(DW), .P(P), .SHIFT(P-1-k)) u_step_y (
      .clk_i, .en_i(en), .rem_i(rem_y[k]), .den_i(den_y[k]), .q_i(q_y[k]),
      .ovf_i(ovf_y[k]), .rem_o(rem_y[k+1]), .den_o(den_y[k+1]), .q_o(q_y[k+1]),
      .ovf_o(ovf_y[k+1])
    );
  end

  // clamp to the image edge and register the result
  logic [P-1:0]       lim_x, lim_y, col_d, row_d;
  logic [P-1:0]       col_q, row_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               wr_q;
  ptd_side_t          side_o;

  always_comb begin
    side_o = side_q[LAST-1];
    if (width_q == '0)                          lim_x = '0;
    else if (18'(width_q) > (18'(1) << P))      lim_x = '1;
    else                                        lim_x = P'(width_q - 1'b1);
    if (height_q == '0)                         lim_y = '0;
    else if (18'(height_q) > (18'(1) << P))     lim_y = '1;
    else                                        lim_y = P'(height_q - 1'b1);
    col_d = (ovf_x[P] || q_x[P] > lim_x) ? lim_x : q_x[P];
    row_d = (ovf_y[P] || q_y[P] > lim_y) ? lim_y : q_y[P];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wr_q    <= side_o.keep;
      col_q   <= side_o.keep ? col_d : '0;
      row_q   <= side_o.keep ? row_d : '0;
      depth_q <= side_o.keep ? side_o.depth : '0;
    end
  end

  assign m_axis_tuser_o = wr_q;
  assign m_axis_tdata_o = OW'({depth_q, row_q, col_q});

  `PTD_ASSERT_SAME(a_reject_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0, "rejected item carries data")
  `PTD_ASSERT_SAME(a_stall_ready, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "input taken while output stalled")
  `PTD_ASSERT_NEXT(a_entry_valid, s_axis_tvalid_i && s_axis_tready_o, valid_q[0], "accepted item lost at entry")
endmodule

// ----- rtl/ptd_axis_front.sv -----
module ptd_axis_front import ptd_pkg::*; #(
  parameter int CB = 24,
  parameter int P  = 12,
  parameter int W  = CB + P + 22,
  parameter int DW = CB + 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CB-1:0] p_i,
  input  logic signed [CB-1:0] z_i,
  input  logic [FOCAL_W-1:0]   focal_i,
  input  logic [FOCAL_W-1:0]   center_i,
  output logic [W-1:0]         rem_o,
  output logic [DW-1:0]        den_o,
  output logic                 ovf_o
);
  localparam int PW = CB + FOCAL_W + 1;
  localparam int NW = PW + 1;

  logic signed [PW-1:0] prod_p_q, prod_c_q;
  logic [CB-1:0]        z_q;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        mag;
  logic [W-1:0]         mag_w, lim_w;
  logic [DW-1:0]        den_d;

  // stage A: the two products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_p_q <= p_i * $signed({1'b0, focal_i});
      prod_c_q <= $signed({1'b0, center_i}) * z_i;
      z_q      <= z_i;
    end
  end

  // stage B: numerator magnitude, denominator, range check
  always_comb begin
    num   = NW'(prod_p_q) + NW'(prod_c_q);
    mag   = num[NW-1] ? NW'(-num) : NW'(num);
    mag_w = W'(mag);
    den_d = {z_q, 8'd0};
    lim_w = W'(den_d) << P;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= mag_w;
      den_o <= den_d;
      ovf_o <= (mag_w >= lim_w);
    end
  end
endmodule

// ----- rtl/ptd_div_step.sv -----
module ptd_div_step #(
  parameter int W     = 58,
  parameter int DW    = 32,
  parameter int P     = 12,
  parameter int SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [P-1:0]  q_i,
  input  logic          ovf_i,
  output logic [W-1:0]  rem_o,
  output logic [DW-1:0] den_o,
  output logic [P-1:0]  q_o,
  output logic          ovf_o
);
  logic [W-1:0] trial;
  logic         ge;
  logic [P-1:0] q_d;

  // one restoring quotient bit
  always_comb begin
    trial    = W'(den_i) << SHIFT;
    ge       = (rem_i >= trial);
    q_d      = q_i;
    q_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? rem_i - trial : rem_i;
      den_o <= den_i;
      q_o   <= q_d;
      ovf_o <= ovf_i;
    end
  end
endmodule
